FILE: rtl/mdc_pkg.sv
// Shared types and constants for the metered dispense controller.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package mdc_pkg;

  localparam int VolW  = 24;   // remaining volume, meter counts
  localparam int TotW  = 32;   // dispensed total, meter counts
  localparam int TimeW = 32;   // seconds
  localparam int EdgeW = 8;
  localparam int CfgW  = 16;
  localparam int CfgIdxW = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDrainSeconds = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgMinReportGap = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxReportGap = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgVolumeChange = 4'd3;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] DrainSecondsReset = 16'd12;
  localparam logic [CfgW-1:0] MinReportGapReset = 16'd5;
  localparam logic [CfgW-1:0] MaxReportGapReset = 16'd3600;
  localparam logic [CfgW-1:0] VolumeChangeReset = 16'd20;

  typedef struct packed {
    logic [TimeW-1:0] now_seconds;
    logic [EdgeW-1:0] flow_edges;
    logic             load_target;
    logic [VolW-1:0]  target_counts;
  } item_t;

  typedef struct packed {
    logic             water_valve;
    logic             drain_valve;
    logic             report_now;
    logic [VolW-1:0]  remaining_counts;
    logic [TotW-1:0]  total_counts;
    logic [TimeW-1:0] report_age;
  } result_t;

  typedef struct packed {
    logic [CfgW-1:0] drain_seconds;
    logic [CfgW-1:0] min_report_gap;
    logic [CfgW-1:0] max_report_gap;
    logic [CfgW-1:0] volume_change_counts;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/mdc_cfg_regs.sv
// Configuration register file of the metered dispense controller.
// Depends on mdc_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module mdc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [mdc_pkg::CfgIdxW-1:0]   wr_index,
  input  wire logic [mdc_pkg::CfgW-1:0]      wr_data,
  output mdc_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drain_seconds        <= mdc_pkg::DrainSecondsReset;
      cfg.min_report_gap       <= mdc_pkg::MinReportGapReset;
      cfg.max_report_gap       <= mdc_pkg::MaxReportGapReset;
      cfg.volume_change_counts <= mdc_pkg::VolumeChangeReset;
    end else if (wr_en) begin
      case (wr_index)
        mdc_pkg::CfgDrainSeconds: cfg.drain_seconds        <= wr_data;
        mdc_pkg::CfgMinReportGap: cfg.min_report_gap       <= wr_data;
        mdc_pkg::CfgMaxReportGap: cfg.max_report_gap       <= wr_data;
        mdc_pkg::CfgVolumeChange: cfg.volume_change_counts <= wr_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mdc_core.sv
// Per-tick update of the dispense controller: volume/total counters, valve
// and drain timer state, published snapshot and report decision. Uses mdc_pkg.
`default_nettype none

module mdc_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mdc_pkg::cfg_t   cfg,
  input  wire mdc_pkg::item_t  item,
  input  wire logic            commit,   // state advances with this item
  output mdc_pkg::result_t     res
);

  localparam int VolW  = mdc_pkg::VolW;
  localparam int TotW  = mdc_pkg::TotW;
  localparam int TimeW = mdc_pkg::TimeW;

  // controller state
  logic [VolW-1:0]  remaining,     remaining_next;
  logic [TotW-1:0]  total,         total_next;
  logic             water_on,      water_on_next;
  logic             drain_on,      drain_on_next;
  logic             drain_timing,  drain_timing_next;
  logic [TimeW-1:0] drain_start,   drain_start_next;
  logic             force_report,  force_report_next;
  // published snapshot
  logic [TimeW-1:0] pub_age;
  logic             pub_water;
  logic             pub_drain;
  logic [VolW-1:0]  pub_remaining;
  logic [TotW-1:0]  pub_total;

  logic [VolW-1:0]  rem_loaded;
  logic             force_loaded;
  logic [TimeW-1:0] age;
  logic [TimeW-1:0] gap;
  logic [TimeW-1:0] drain_elapsed;
  logic [VolW-1:0]  rem_diff;
  logic [TotW-1:0]  tot_diff;
  logic             report;

  always_comb begin
    rem_loaded   = item.load_target ? item.target_counts : remaining;
    force_loaded = item.load_target | force_report;
    age = (item.now_seconds > pub_age) ? item.now_seconds : pub_age;

    water_on_next     = water_on;
    drain_on_next     = drain_on;
    drain_timing_next = drain_timing;
    drain_start_next  = drain_start;
    total_next        = total;
    remaining_next    = rem_loaded;

    if (rem_loaded != '0) begin
      drain_timing_next = 1'b0;
      water_on_next     = 1'b1;
    end

    if (!drain_timing_next) begin
      total_next = total + TotW'(item.flow_edges);
      if (VolW'(item.flow_edges) > rem_loaded) begin
        // overshoot: close supply, open drain and start its timer
        remaining_next    = '0;
        drain_start_next  = item.now_seconds;
        drain_timing_next = 1'b1;
        water_on_next     = 1'b0;
        drain_on_next     = 1'b1;
      end else begin
        remaining_next = rem_loaded - VolW'(item.flow_edges);
      end
    end

    drain_elapsed = item.now_seconds - drain_start_next;
    if (!drain_timing_next || drain_elapsed > TimeW'(cfg.drain_seconds)) begin
      drain_timing_next = 1'b0;
      drain_on_next     = 1'b0;
    end

    rem_diff = (remaining_next >= pub_remaining) ? remaining_next - pub_remaining
                                                 : pub_remaining - remaining_next;
    tot_diff = (total_next >= pub_total) ? total_next - pub_total
                                         : pub_total - total_next;

    gap = age - pub_age;
    if (force_loaded) begin
      report = 1'b1;
    end else if (gap < TimeW'(cfg.min_report_gap)) begin
      report = 1'b0;
    end else if (gap > TimeW'(cfg.max_report_gap)) begin
      report = 1'b1;
    end else begin
      report = (water_on_next != pub_water) || (drain_on_next != pub_drain) ||
               (rem_diff >= VolW'(cfg.volume_change_counts)) ||
               (tot_diff >= TotW'(cfg.volume_change_counts));
    end

    force_report_next = force_loaded & ~report;

    res.water_valve      = water_on_next;
    res.drain_valve      = drain_on_next;
    res.report_now       = report;
    res.remaining_counts = remaining_next;
    res.total_counts     = total_next;
    res.report_age       = age;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining     <= '0;
      total         <= '0;
      water_on      <= 1'b0;
      drain_on      <= 1'b0;
      drain_timing  <= 1'b0;
      drain_start   <= '0;
      force_report  <= 1'b0;
      pub_age       <= '0;
      pub_water     <= 1'b0;
      pub_drain     <= 1'b0;
      pub_remaining <= '0;
      pub_total     <= '0;
    end else if (commit) begin
      remaining    <= remaining_next;
      total        <= total_next;
      water_on     <= water_on_next;
      drain_on     <= drain_on_next;
      drain_timing <= drain_timing_next;
      drain_start  <= drain_start_next;
      force_report <= force_report_next;
      if (report) begin
        pub_age       <= age;
        pub_water     <= water_on_next;
        pub_drain     <= drain_on_next;
        pub_remaining <= remaining_next;
        pub_total     <= total_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/metered_dispense_controller_top.sv
// Metered dispense controller top: input register, update core, result register.
// An item goes to the input register, then to the result register (2 register stages).
// Throughput: one item per cycle; the update is one combinational pass and the state
// commits with it. The input stalls only while both registers hold and the receiver stalls.
// Reset (rst, synchronous, active high): state and published snapshot go to zero;
// config registers return to 12 / 5 / 3600 / 20. Uses mdc_pkg, mdc_cfg_regs, mdc_core.
`default_nettype none

module metered_dispense_controller_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // item channel
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire mdc_pkg::item_t              item,
  // result channel
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output mdc_pkg::result_t                 result,
  // config write channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mdc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [mdc_pkg::CfgW-1:0]    cfg_data
);

  mdc_pkg::cfg_t    cfg;
  mdc_pkg::item_t   stage_item;     // input register
  logic             stage_valid;
  mdc_pkg::result_t core_result;

  logic result_free;   // result register can take a new value this cycle
  logic advance;       // staged item moves into the result register
  logic item_xfer;     // item transfer on the input channel

  // Config writes are always taken; the user must keep the block idle whenever they arrive, unchecked.
  assign cfg_ready = 1'b1;

  mdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The result register empties or gets taken -> staged item can move on.
  // A new item is taken whenever the stage is empty or moving.
  assign result_free = ~result_valid | ~result_stall;
  assign advance     = stage_valid & result_free;
  assign item_stall  = stage_valid & ~result_free;
  assign item_xfer   = item_valid & ~item_stall;

  // State inside the core updates on the same edge the result is captured,
  // so the next staged item already sees it.
  mdc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (stage_item),
    .commit (advance),
    .res    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      stage_valid  <= item_xfer | (stage_valid & ~advance);
      result_valid <= advance | (result_valid & result_stall);
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      stage_item <= item;
    end
    if (advance) begin
      result <= core_result;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mdc_checker.sv
// Port-level checks for the metered dispense controller, bound to the top level.
// Depends on mdc_pkg for the result struct.
`default_nettype none

module mdc_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_stall,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire mdc_pkg::result_t result
);

  // a held result keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // supply and drain valves never open together
  a_valves_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.water_valve && result.drain_valve))
    else $error("water and drain valve both open");

  // volume left means the supply valve is open
  a_water_with_volume: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.remaining_counts != '0) |-> result.water_valve)
    else $error("volume remains with water valve closed");

  // draining only once volume has run out
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.drain_valve |-> result.remaining_counts == '0)
    else $error("drain open with volume remaining");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("pipeline not empty after reset");

endmodule

bind metered_dispense_controller_top mdc_checker u_mdc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for metered_dispense_controller_top: directed ticks, then
// random ticks across several register settings, with random sender bursts and receiver stalls.
// Depends on mdc_pkg and the RTL of the block; reads no files.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mdc_pkg::*;

  localparam int Latency    = 2;     // item transfer to result, in register stages
  localparam int LongHold   = 300;   // receiver hold-off, cycles
  localparam int SqueezeLen = 60;    // back-to-back items sent during a hold-off
  localparam int PhaseItems = 175;
  localparam int PrintCap   = 40;    // mismatch lines printed before going quiet

  localparam logic [CfgIdxW-1:0] CfgFirstUnused = CfgVolumeChange + 1'b1;

  // Predicts the block tick by tick and holds the results still to arrive.
  class dispense_scoreboard;
    logic [CfgW-1:0]  drain_secs, min_gap, max_gap, change_thr;
    logic [VolW-1:0]  remaining;
    logic [TotW-1:0]  total;
    bit               water, drain, drain_timing, force_pub;
    logic [TimeW-1:0] drain_t0;
    logic [TimeW-1:0] pub_age;
    bit               pub_water, pub_drain;
    logic [VolW-1:0]  pub_remaining;
    logic [TotW-1:0]  pub_total;
    result_t          due_q[$];
    int               errors, n_items, n_results, n_reports, n_drains;

    function new();
      drain_secs = DrainSecondsReset;
      min_gap    = MinReportGapReset;
      max_gap    = MaxReportGapReset;
      change_thr = VolumeChangeReset;
      remaining = '0; total = '0; water = 0; drain = 0; drain_timing = 0; force_pub = 0;
      drain_t0 = '0; pub_age = '0; pub_water = 0; pub_drain = 0;
      pub_remaining = '0; pub_total = '0;
      errors = 0; n_items = 0; n_results = 0; n_reports = 0; n_drains = 0;
    endfunction

    function void set_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CfgDrainSeconds: drain_secs = data;
        CfgMinReportGap: min_gap    = data;
        CfgMaxReportGap: max_gap    = data;
        CfgVolumeChange: change_thr = data;
        default: ;  // unmapped index, ignored
      endcase
    endfunction

    // One control tick: update the state and queue the expected result.
    function void note_item(item_t it);
      result_t          r;
      logic [TimeW-1:0] age, gap;
      logic [VolW-1:0]  d_rem;
      logic [TotW-1:0]  d_tot;
      bit               publish;
      n_items++;
      if (it.load_target) begin
        remaining = it.target_counts;
        force_pub = 1;
      end
      age = (it.now_seconds > pub_age) ? it.now_seconds : pub_age;
      if (remaining != 0) begin
        drain_timing = 0;
        water = 1;
      end
      if (!drain_timing) begin
        total = total + it.flow_edges;
        if (it.flow_edges > remaining) begin
          // overshoot: close water, start drain timer
          remaining = '0;
          drain_t0 = it.now_seconds;
          drain_timing = 1;
          water = 0;
          drain = 1;
          n_drains++;
        end else begin
          remaining = remaining - it.flow_edges;
        end
      end
      if (!drain_timing || (it.now_seconds - drain_t0) > drain_secs) begin
        drain_timing = 0;
        drain = 0;
      end
      gap   = age - pub_age;
      d_rem = (remaining >= pub_remaining) ? remaining - pub_remaining : pub_remaining - remaining;
      d_tot = (total >= pub_total) ? total - pub_total : pub_total - total;
      if (force_pub) publish = 1;
      else if (gap < min_gap) publish = 0;
      else if (gap > max_gap) publish = 1;
      else publish = (water != pub_water) || (drain != pub_drain) ||
                     (d_rem >= change_thr) || (d_tot >= change_thr);
      if (publish) begin
        force_pub = 0;
        pub_age = age;
        pub_water = water;
        pub_drain = drain;
        pub_remaining = remaining;
        pub_total = total;
        n_reports++;
      end
      r.water_valve      = water;
      r.drain_valve      = drain;
      r.report_now       = publish;
      r.remaining_counts = remaining;
      r.total_counts     = total;
      r.report_age       = age;
      due_q.push_back(r);
    endfunction

    task flag_mismatch(string what, longint unsigned want, longint unsigned got);
      errors++;
      if (errors <= PrintCap)
        $display("%0t MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                 $realtime, n_results, what, want, got);
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        flag_mismatch("unexpected result", 64'(0), 64'(got.report_age));
        return;
      end
      want = due_q.pop_front();
      if (got.water_valve !== want.water_valve)
        flag_mismatch("water_valve", 64'(want.water_valve), 64'(got.water_valve));
      if (got.drain_valve !== want.drain_valve)
        flag_mismatch("drain_valve", 64'(want.drain_valve), 64'(got.drain_valve));
      if (got.report_now !== want.report_now)
        flag_mismatch("report_now", 64'(want.report_now), 64'(got.report_now));
      if (got.remaining_counts !== want.remaining_counts)
        flag_mismatch("remaining_counts", 64'(want.remaining_counts),
                      64'(got.remaining_counts));
      if (got.total_counts !== want.total_counts)
        flag_mismatch("total_counts", 64'(want.total_counts), 64'(got.total_counts));
      if (got.report_age !== want.report_age)
        flag_mismatch("report_age", 64'(want.report_age), 64'(got.report_age));
      n_results++;
    endtask

    function int pending();
      return due_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------- signals
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  item_t               item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgW-1:0]     cfg_data = '0;

  dispense_scoreboard  sb = new();

  logic [TimeW-1:0]    clock_s = '0;   // running wall clock for well-formed ticks
  int                  n_settings = 1; // reset values count as the first setting
  logic                hold_ask = 1'b0;
  logic                hold_seen = 1'b0;

  metered_dispense_controller_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ------------------------------------------------------- result receiver
  // Stall pattern: stretches of no stalls, light stalls and heavy stalls,
  // plus a long hold-off whenever the stimulus asks for one (hold_ask toggles).
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen    <= hold_ask;
      hold_left    <= LongHold;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Outputs are sampled at the edge, before the block updates them.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // ------------------------------------------------------------ stimulus
  // Called at a rising edge; leaves item_valid high so the next transfer can
  // follow without a bubble.
  task automatic send_item(item_t it);
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  task automatic tick(logic [TimeW-1:0] now, logic [EdgeW-1:0] edges, logic load,
                      logic [VolW-1:0] target);
    item_t it;
    it.now_seconds   = now;
    it.flow_edges    = edges;
    it.load_target   = load;
    it.target_counts = target;
    send_item(it);
  endtask

  // Sender goes quiet until every expected result is back, then lets the
  // pipeline settle before any register write.
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_cfg(idx, data);
  endtask

  task automatic apply_settings(logic [CfgW-1:0] drain_s, logic [CfgW-1:0] min_g,
                                logic [CfgW-1:0] max_g, logic [CfgW-1:0] change,
                                bit with_unmapped);
    cfg_write(CfgDrainSeconds, drain_s);
    // a write to an unmapped index must leave everything alone
    if (with_unmapped)
      cfg_write(CfgIdxW'($urandom_range(CfgFirstUnused, (1 << CfgIdxW) - 1)),
                CfgW'($urandom));
    cfg_write(CfgMinReportGap, min_g);
    cfg_write(CfgMaxReportGap, max_g);
    cfg_write(CfgVolumeChange, change);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // Mostly a clock that creeps forward with small meter counts and the odd
  // new target; some jumps and backward steps; a share of pure noise.
  function automatic item_t make_item();
    item_t it;
    int    roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      it.now_seconds   = TimeW'($urandom);
      it.flow_edges    = EdgeW'($urandom);
      it.load_target   = 1'($urandom);
      it.target_counts = VolW'($urandom);
      return it;
    end
    if (roll < 10) clock_s = TimeW'($urandom);
    else if (roll < 12) clock_s = clock_s - $urandom_range(1, 40);
    else clock_s = clock_s + $urandom_range(0, 3);
    it.now_seconds   = clock_s;
    it.flow_edges    = ($urandom_range(0, 9) == 0) ? EdgeW'($urandom_range(0, 255))
                                                   : EdgeW'($urandom_range(0, 30));
    it.load_target   = ($urandom_range(0, 14) == 0);
    it.target_counts = ($urandom_range(0, 9) == 0) ? VolW'($urandom)
                                                   : VolW'($urandom_range(0, 600));
    return it;
  endfunction

  // Random bursts with random gaps. With squeeze set, the receiver is told
  // to hold off and the first items go back to back so the block backs up.
  task automatic run_phase(int n_items, bit squeeze);
    int sent, burst, gap, tight;
    sent  = 0;
    tight = 0;
    if (squeeze) begin
      hold_ask <= ~hold_ask;
      tight = SqueezeLen;
    end
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        send_item(make_item());
        sent++;
        if (tight != 0) tight--;
      end
      if (tight == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 24) == 0) begin
          // occasional full drain of the pipeline mid-phase
          item_valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end else if (gap != 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // ----------------------------------------------------------- main flow
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed ticks at reset settings (drain 12 s, gaps 5/3600, change 20).
    tick(32'd0, 8'd0, 1'b0, 24'd0);                // idle, nothing to publish
    tick(32'd1, 8'd0, 1'b1, 24'd100);              // new target forces a report
    tick(32'd2, 8'd60, 1'b0, 24'd0);
    tick(32'd3, 8'd40, 1'b0, 24'd0);               // lands exactly on zero, water stays open
    tick(32'd4, 8'd1, 1'b0, 24'd0);                // overshoot: drain opens at t=4
    tick(32'd5, 8'd255, 1'b0, 24'hFF_FFFF);        // edges while draining are ignored
    tick(32'd16, 8'd0, 1'b0, 24'd0);               // 12 s elapsed, not yet more than drain time
    tick(32'd17, 8'd0, 1'b0, 24'd0);               // drain closes
    tick(32'd20, 8'd0, 1'b1, 24'hFF_FFFF);         // largest target
    tick(32'd21, 8'd255, 1'b0, 24'd0);
    tick(32'hAAAA_AAAA, 8'h55, 1'b0, 24'h55_5555);
    tick(32'h5555_5555, 8'hAA, 1'b1, 24'hAA_AAAA);
    tick(32'hFFFF_FFFF, 8'd255, 1'b0, 24'd0);      // top of time range
    tick(32'd30, 8'd7, 1'b0, 24'd0);               // time steps backwards
    tick(32'd31, 8'd0, 1'b1, 24'd0);               // zero target
    tick(32'd32, 8'd1, 1'b0, 24'd0);               // overshoot from empty
    tick(32'd10, 8'd3, 1'b0, 24'd0);               // backwards during drain ends it
    tick(32'd40, 8'd0, 1'b1, 24'd5);
    tick(32'd41, 8'd5, 1'b0, 24'd0);
    tick(32'd42, 8'd255, 1'b0, 24'd0);
    clock_s = 32'd100;
    settle();

    run_phase(PhaseItems, 1'b0);                   // reset settings
    settle();
    apply_settings('0, '0, '0, '0, 1'b0);          // everything zero: report every tick
    run_phase(PhaseItems, 1'b0);
    settle();
    apply_settings('1, '1, '1, '1, 1'b0);          // everything at maximum
    run_phase(PhaseItems, 1'b1);
    settle();
    apply_settings(16'd3, 16'd50, 16'd10, 16'd1, 1'b0);  // min gap above max gap
    run_phase(PhaseItems, 1'b0);
    settle();
    apply_settings(CfgW'($urandom_range(0, 40)), CfgW'($urandom_range(0, 20)),
                   CfgW'($urandom_range(0, 200)), CfgW'($urandom_range(1, 60)), 1'b1);
    run_phase(PhaseItems, 1'b1);
    settle();
    apply_settings(16'd2, 16'd1, 16'd30, 16'd5, 1'b1);
    run_phase(PhaseItems, 1'b0);
    settle();

    $display("Covered %0d ticks and %0d checked results: %0d snapshots published, %0d drains",
             sb.n_items, sb.n_results, sb.n_reports, sb.n_drains);
    $display("over %0d register settings incl. all-zero, all-max and crossed report gaps",
             n_settings);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
